// ===== src/modlog_pkg.sv =====
package modlog_pkg;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_NOT_REACHED = 2'd2;

  localparam int OPND_BITS = 16;
  localparam int EXP_BITS  = 16;

  // Which operands feed the shared remainder unit.
  typedef enum logic [1:0] {
    REM_GCD    = 2'd0,
    REM_BASE   = 2'd1,
    REM_TARGET = 2'd2,
    REM_PROD   = 2'd3
  } rem_src_t;

  // Kind of result written into the output registers.
  typedef enum logic [1:0] {
    FIN_INVALID     = 2'd0,
    FIN_ZERO_OK     = 2'd1,
    FIN_EXP_OK      = 2'd2,
    FIN_NOT_REACHED = 2'd3
  } fin_kind_t;

  typedef struct packed {
    logic      load;
    logic      gcd_step;
    logic      rem_start;
    rem_src_t  rem_src;
    logic      set_base;
    logic      set_target;
    logic      mul;
    logic      set_pow;
    logic      finish;
    fin_kind_t fin_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic n_lt2;
    logic m_zero;
    logic gb_zero;
    logic ga_one;
    logic rem_done;
    logic k_one;
    logic p_one;
    logic p_eq_k;
  } dp_sts_t;

endpackage

// ===== src/modlog_rem.sv =====
module modlog_rem #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [W-1:0]   rem
);

  localparam int CW = $clog2(2 * W + 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [2*W-1:0] div_r;
  logic [W-1:0]   dsr_r;
  logic [W-1:0]   rem_r;
  logic [W:0]     shifted;
  logic [W:0]     diff;
  logic           fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign shifted = {rem_r, div_r[2*W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(2 * W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      div_r <= div_r << 1;
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit restarted while busy");

endmodule

// ===== src/modlog_dp.sv =====
module modlog_dp #(
  parameter int W = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_operation,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_modulus,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_base,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_target,
  input  modlog_pkg::dp_cmd_t              cmd,
  output modlog_pkg::dp_sts_t              sts,
  output logic [1:0]                       out_status,
  output logic [modlog_pkg::EXP_BITS-1:0]  out_exponent
);

  import modlog_pkg::*;

  localparam int EW = (W > OPND_BITS) ? W : OPND_BITS;

  logic           op_r;
  logic [W-1:0]   n_r, m_r, k_r, b_r, p_r, e_r, ga_r, gb_r;
  logic [2*W-1:0] prod_r;
  logic [1:0]     status_r;
  logic [EXP_BITS-1:0] exp_r;

  logic [EW-1:0]  n_ext, m_ext, k_ext, e_ext;
  logic [2*W-1:0] rem_dividend;
  logic [W-1:0]   rem_divisor;
  logic           rem_done;
  logic [W-1:0]   rem_val;

  // Only the low W bits of each operand take part.
  assign n_ext = EW'(in_modulus);
  assign m_ext = EW'(in_base);
  assign k_ext = EW'(in_target);
  assign e_ext = EW'(e_r);

  always_comb begin
    rem_divisor = n_r;
    case (cmd.rem_src)
      REM_GCD: begin
        rem_dividend = {{W{1'b0}}, ga_r};
        rem_divisor  = gb_r;
      end
      REM_BASE:   rem_dividend = {{W{1'b0}}, m_r};
      REM_TARGET: rem_dividend = {{W{1'b0}}, k_r};
      REM_PROD:   rem_dividend = prod_r;
      default:    rem_dividend = prod_r;
    endcase
  end

  modlog_rem #(.W(W)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      n_r  <= n_ext[W-1:0];
      m_r  <= m_ext[W-1:0];
      k_r  <= k_ext[W-1:0];
      ga_r <= n_ext[W-1:0];
      gb_r <= m_ext[W-1:0];
    end
    if (cmd.gcd_step) begin
      ga_r <= gb_r;
      gb_r <= rem_val;
    end
    if (cmd.set_base) begin
      b_r <= rem_val;
      p_r <= rem_val;
      e_r <= W'(1);
    end
    if (cmd.set_target) begin
      k_r <= rem_val;
    end
    if (cmd.mul) begin
      prod_r <= p_r * b_r;
    end
    if (cmd.set_pow) begin
      p_r <= rem_val;
      e_r <= e_r + W'(1);
    end
    if (cmd.finish) begin
      case (cmd.fin_kind)
        FIN_INVALID: begin
          status_r <= ST_INVALID;
          exp_r    <= '0;
        end
        FIN_ZERO_OK: begin
          status_r <= ST_OK;
          exp_r    <= '0;
        end
        FIN_EXP_OK: begin
          status_r <= ST_OK;
          exp_r    <= e_ext[EXP_BITS-1:0];
        end
        default: begin
          status_r <= ST_NOT_REACHED;
          exp_r    <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.n_lt2    = n_r < W'(2);
    sts.m_zero   = m_r == '0;
    sts.gb_zero  = gb_r == '0;
    sts.ga_one   = ga_r == W'(1);
    sts.rem_done = rem_done;
    sts.k_one    = k_r == W'(1);
    sts.p_one    = p_r == W'(1);
    sts.p_eq_k   = p_r == k_r;
  end

  assign out_status   = status_r;
  assign out_exponent = exp_r;

endmodule

// ===== src/modlog_ctrl.sv =====
module modlog_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output modlog_pkg::dp_cmd_t cmd,
  input  modlog_pkg::dp_sts_t sts
);

  import modlog_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_CHECK     = 11'b000_0000_0010,
    S_GCD_TEST  = 11'b000_0000_0100,
    S_GCD_WAIT  = 11'b000_0000_1000,
    S_MODB_WAIT = 11'b000_0001_0000,
    S_MODK_WAIT = 11'b000_0010_0000,
    S_LOG_CHK   = 11'b000_0100_0000,
    S_LOOP_TEST = 11'b000_1000_0000,
    S_MUL       = 11'b001_0000_0000,
    S_MUL_REM   = 11'b010_0000_0000,
    S_MUL_WAIT  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.rem_src   = REM_GCD;
    cmd.fin_kind  = FIN_INVALID;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.n_lt2 || sts.m_zero) begin
          cmd.finish    = 1'b1;
          cmd.fin_kind  = FIN_INVALID;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_GCD_TEST;
        end
      end
      S_GCD_TEST: begin
        cmd.rem_start = 1'b1;
        if (!sts.gb_zero) begin
          cmd.rem_src = REM_GCD;
          state_nxt   = S_GCD_WAIT;
        end else if (sts.ga_one) begin
          cmd.rem_src = REM_BASE;
          state_nxt   = S_MODB_WAIT;
        end else begin
          cmd.rem_start = 1'b0;
          cmd.finish    = 1'b1;
          cmd.fin_kind  = FIN_INVALID;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GCD_WAIT: begin
        if (sts.rem_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_GCD_TEST;
        end
      end
      S_MODB_WAIT: begin
        if (sts.rem_done) begin
          cmd.set_base = 1'b1;
          if (sts.op) begin
            cmd.rem_start = 1'b1;
            cmd.rem_src   = REM_TARGET;
            state_nxt     = S_MODK_WAIT;
          end else begin
            state_nxt = S_LOOP_TEST;
          end
        end
      end
      S_MODK_WAIT: begin
        if (sts.rem_done) begin
          cmd.set_target = 1'b1;
          state_nxt      = S_LOG_CHK;
        end
      end
      S_LOG_CHK: begin
        if (sts.k_one) begin
          cmd.finish    = 1'b1;
          cmd.fin_kind  = FIN_ZERO_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_LOOP_TEST;
        end
      end
      S_LOOP_TEST: begin
        if (sts.p_one) begin
          cmd.finish    = 1'b1;
          cmd.fin_kind  = sts.op ? FIN_NOT_REACHED : FIN_EXP_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.op && sts.p_eq_k) begin
          cmd.finish    = 1'b1;
          cmd.fin_kind  = FIN_EXP_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MUL_REM;
      end
      S_MUL_REM: begin
        cmd.rem_start = 1'b1;
        cmd.rem_src   = REM_PROD;
        state_nxt     = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts.rem_done) begin
          cmd.set_pow = 1'b1;
          state_nxt   = S_LOOP_TEST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while the sequencer is not idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two result strobes in a row");

endmodule

// ===== src/modular_order_and_discrete_log_unit.sv =====
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+-------------------------
// input    | in_operation, in_modulus, in_base, in_target   | start high, busy low
// result   | out_status, out_exponent                       | out_valid for one cycle
//
// An item runs the Euclidean gcd check step by step, then reduces the base and, for a
// discrete-log search, the target, then computes each power of the base in turn; every
// step goes through the shared bit-serial remainder unit, which paces the whole item.
// Reset is synchronous and active low; it idles the sequencer and clears the strobe.
// The receiver cannot stall: each result shows for one cycle, with busy already low.
module modular_order_and_discrete_log_unit #(
  parameter int MOD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_modulus,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_base,
  input  logic [modlog_pkg::OPND_BITS-1:0] in_target,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [modlog_pkg::EXP_BITS-1:0]  out_exponent
);

  import modlog_pkg::*;

  // The sequencer drives the datapath with one command word per cycle and reads
  // back a handful of compare flags; all arithmetic lives in the datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  modlog_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the operands, the running power and exponent, one
  // multiplier with a product register, and the shared remainder unit.
  modlog_dp #(.W(MOD_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_modulus   (in_modulus),
    .in_base      (in_base),
    .in_target    (in_target),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_status),
    .out_exponent (out_exponent)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import modlog_pkg::*;

  // Each step of a search computes one more power of the base through the
  // serial remainder unit.
  // The stimulus keeps search lengths short, so this cap on idle cycles is generous.
  localparam int IDLE_LIMIT  = 300000;
  localparam int DRAIN_WAIT  = 200;
  localparam int RAND_ITEMS  = 100;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] exponent;
  } outcome_t;

  typedef struct {
    logic        op;
    logic [15:0] modulus;
    logic [15:0] base;
    logic [15:0] target;
    bit          typed;   // expected result written into the row
    outcome_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [15:0] in_modulus;
  logic [15:0] in_base;
  logic [15:0] in_target;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_exponent;

  outcome_t pending_results[$];
  int       error_count;
  int       idle_cycles;
  logic     accepted_now;
  stim_row_t directed[$];

  modular_order_and_discrete_log_unit #(.MOD_BITS(16)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_modulus(in_modulus),
    .in_base(in_base), .in_target(in_target),
    .out_valid(out_valid), .out_status(out_status), .out_exponent(out_exponent)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // High in the cycle whose closing edge takes an item.
  assign accepted_now = start & !busy;

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Predicts the order of the base, or the first exponent reaching the target.
  function automatic outcome_t order_or_log(logic op, logic [15:0] n_in,
                                            logic [15:0] m_in, logic [15:0] k_in);
    longint unsigned n, b, k, p, e;
    outcome_t r;
    n = 64'(n_in);
    k = 64'(k_in);
    r.status = ST_INVALID;
    r.exponent = '0;
    if (n < 2 || m_in == 0 || gcd_of(n, 64'(m_in)) != 1) return r;
    b = 64'(m_in) % n;
    p = b;
    e = 1;
    r.status = ST_OK;
    if (op == 1'b0) begin
      while (p != 1) begin
        p = (p * b) % n;
        e++;
      end
      r.exponent = e[15:0];
      return r;
    end
    k = k % n;
    if (k == 1) return r;
    while (p != 1) begin
      if (p == k) begin
        r.exponent = e[15:0];
        return r;
      end
      p = (p * b) % n;
      e++;
    end
    r.status = ST_NOT_REACHED;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // Results are sampled at the edge that ends their one-cycle strobe.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status)
          report_mismatch("status", int'(out_status), int'(exp_r.status));
        if (out_exponent !== exp_r.exponent)
          report_mismatch("exponent", int'(out_exponent), int'(exp_r.exponent));
      end
    end
  end

  // The watchdog restarts whenever an item is taken or a result comes out.
  always @(posedge clk) begin
    if (accepted_now || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Drives one item and holds it until the block takes it. Unless a gap follows,
  // start stays high on return so that a burst can continue without start dropping.
  task automatic send_item(logic op, logic [15:0] n, logic [15:0] m, logic [15:0] k,
                           bit typed, outcome_t want);
    outcome_t model_r;
    model_r = order_or_log(op, n, m, k);
    start        <= 1'b1;
    in_operation <= op;
    in_modulus   <= n;
    in_base      <= m;
    in_target    <= k;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed && model_r != want) report_mismatch("table row", int'(model_r), int'(want));
    pending_results.push_back(typed ? want : model_r);
    // Gaps between bursts; a burst keeps start high.
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t make_row(logic op, logic [15:0] n, logic [15:0] m,
                                         logic [15:0] k, bit typed,
                                         logic [1:0] st, logic [15:0] e);
    stim_row_t r;
    r.op = op;
    r.modulus = n;
    r.base = m;
    r.target = k;
    r.typed = typed;
    r.want.status = st;
    r.want.exponent = e;
    return r;
  endfunction

  // Lifts a residue to a random 16-bit value with the same residue.
  function automatic logic [15:0] lift(int unsigned res, int unsigned n);
    int unsigned top;
    top = (65535 - res) / n;
    return 16'(res + n * $urandom_range(0, top));
  endfunction

  initial begin
    int unsigned n, m, b, p, steps, kind;
    logic op;
    logic [15:0] k;
    outcome_t none;

    none = '0;
    error_count  = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = 1'b0;
    in_modulus   = '0;
    in_base      = '0;
    in_target    = '0;

    // Invalid inputs: modulus below two, zero base, shared factor.
    directed.push_back(make_row(1'b0, 16'd0, 16'd3, 16'd0, 1'b1, ST_INVALID, 16'd0));
    directed.push_back(make_row(1'b1, 16'd1, 16'd3, 16'd1, 1'b1, ST_INVALID, 16'd0));
    directed.push_back(make_row(1'b0, 16'd7, 16'd0, 16'd0, 1'b1, ST_INVALID, 16'd0));
    directed.push_back(make_row(1'b1, 16'd65534, 16'd65534, 16'hFFFF, 1'b1, ST_INVALID,
                                16'd0));
    // Base congruent to one.
    directed.push_back(make_row(1'b0, 16'd10, 16'd11, 16'hFFFF, 1'b1, ST_OK, 16'd1));
    directed.push_back(make_row(1'b1, 16'd10, 16'd11, 16'd21, 1'b1, ST_OK, 16'd0));
    directed.push_back(make_row(1'b1, 16'd10, 16'd11, 16'd3, 1'b1, ST_NOT_REACHED, 16'd0));
    // Target congruent to one gives exponent zero at once.
    directed.push_back(make_row(1'b1, 16'd7, 16'd3, 16'd8, 1'b1, ST_OK, 16'd0));
    // Target zero is never reached.
    directed.push_back(make_row(1'b1, 16'd7, 16'd3, 16'd14, 1'b1, ST_NOT_REACHED, 16'd0));
    // Extremes: largest modulus with base of order two, and smallest modulus with largest base.
    directed.push_back(make_row(1'b0, 16'd65535, 16'd65534, 16'd0, 1'b1, ST_OK, 16'd2));
    directed.push_back(make_row(1'b1, 16'd65535, 16'd65534, 16'd65534, 1'b1, ST_OK,
                                16'd1));
    directed.push_back(make_row(1'b1, 16'd65535, 16'd65534, 16'd2, 1'b1, ST_NOT_REACHED,
                                16'd0));
    directed.push_back(make_row(1'b0, 16'd2, 16'd65535, 16'd0, 1'b1, ST_OK, 16'd1));
    // Ordinary searches, checked by the predictor.
    directed.push_back(make_row(1'b0, 16'd7, 16'd3, 16'd0, 1'b0, ST_OK, 16'd0));
    directed.push_back(make_row(1'b1, 16'd7, 16'd3, 16'd5, 1'b0, ST_OK, 16'd0));
    directed.push_back(make_row(1'b0, 16'd251, 16'd6, 16'd0, 1'b0, ST_OK, 16'd0));
    directed.push_back(make_row(1'b1, 16'd15, 16'd2, 16'd7, 1'b0, ST_OK, 16'd0));
    directed.push_back(make_row(1'b1, 16'd251, 16'd65530, 16'hAAAA, 1'b0, ST_OK, 16'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].modulus, directed[i].base,
                directed[i].target, directed[i].typed, directed[i].want);

    // Hold off until the table has fully drained.
    wait_for_drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) wait_for_drain();
      kind = $urandom_range(0, 9);
      op = 1'($urandom_range(0, 1));
      k = 16'($urandom);
      if (kind <= 5) begin
        // Small modulus keeps the power search short; the base is a full
        // 16-bit value. For a search, the target is usually a real power.
        n = $urandom_range(2, 255);
        m = $urandom_range(1, 65535);
        b = m % n;
        if (op && kind <= 3 && b != 0) begin
          p = b;
          steps = $urandom_range(0, 300);
          repeat (steps) p = (p * b) % n;
          k = lift(p, n);
        end
      end else if (kind <= 7) begin
        // Modulus anywhere up to 65535, base of order one or two.
        n = $urandom_range(2, 65535);
        m = 32'(lift(($urandom_range(0, 1) ? n - 1 : 1) % n, n));
        if (m == 0) m = 1;
        if (op && $urandom_range(0, 1)) k = lift(m % n, n);
      end else if (kind == 8) begin
        // Shared factor of two.
        n = 2 * $urandom_range(1, 32767);
        m = 2 * $urandom_range(0, 32767);
      end else begin
        n = $urandom_range(0, 1);
        m = $urandom_range(0, 65535);
      end
      send_item(op, 16'(n), 16'(m), k, 1'b0, none);
    end

    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/modlog_pkg.sv
src/modlog_rem.sv
src/modlog_dp.sv
src/modlog_ctrl.sv
src/modular_order_and_discrete_log_unit.sv
bench/tb.sv
